// ===== hdl/ccu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ccu_pkg;
  localparam int RESULT_BITS = 64;
  localparam int ROW_DEPTH = 128;
  localparam int ROW_AW = 7;
  localparam int CAT_DEPTH = 64;
  localparam int CAT_AW = 6;

  localparam logic [2:0] FN_BINOM = 3'd0;
  localparam logic [2:0] FN_LATTICE = 3'd1;
  localparam logic [2:0] FN_CATALAN = 3'd2;
  localparam logic [2:0] FN_MOTZKIN = 3'd3;
  localparam logic [2:0] FN_MULTISET = 3'd4;

  localparam logic [RESULT_BITS-1:0] MAX_VALUE = {RESULT_BITS{1'b1}};

  // Saturating value: count plus overflow mark.
  typedef struct packed {
    logic                   o;
    logic [RESULT_BITS-1:0] v;
  } sat_t;

  // Datapath operation codes issued by the controller.
  localparam logic [4:0] OP_NOP = 5'd0;
  localparam logic [4:0] OP_ROW_INIT = 5'd1;   // row[0]=1, others invalid
  localparam logic [4:0] OP_ROW_RD = 5'd2;     // read row[j] and row[j-1]
  localparam logic [4:0] OP_ROW_WR = 5'd3;     // row[j] = sum
  localparam logic [4:0] OP_CAT_INIT = 5'd4;   // cat[0]=1, acc=0
  localparam logic [4:0] OP_CAT_RD = 5'd5;     // read cat[j], cat[i-1-j]
  localparam logic [4:0] OP_CAT_MUL = 5'd6;    // start multiply
  localparam logic [4:0] OP_CAT_ACC = 5'd7;    // acc += product
  localparam logic [4:0] OP_CAT_WR = 5'd8;     // cat[i] = acc
  localparam logic [4:0] OP_RES_ROW = 5'd9;    // read row[k] into result
  localparam logic [4:0] OP_RES_CAT = 5'd10;   // read cat[n] into result
  localparam logic [4:0] OP_RES_ZERO = 5'd11;
  localparam logic [4:0] OP_RES_ONE = 5'd12;
  localparam logic [4:0] OP_MZ_RD = 5'd13;     // read row[2j], cat[j]
  localparam logic [4:0] OP_MZ_MUL = 5'd14;
  localparam logic [4:0] OP_MZ_ACC = 5'd15;    // result += product
  localparam logic [4:0] OP_ROW_ZERO = 5'd16;  // row[i] = 0

  typedef struct packed {
    logic [4:0]        op;
    logic [ROW_AW-1:0] ra;   // first row address
    logic [ROW_AW-1:0] rb;   // second row address
    logic [CAT_AW-1:0] ca;
    logic [CAT_AW-1:0] cb;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/ccu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ccu_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [5:0] operand_n;
  logic [5:0] operand_k;
  modport source (output valid, func, operand_n, operand_k, input ready);
  modport sink (input valid, func, operand_n, operand_k, output ready);
endinterface

interface ccu_out_if;
  logic                            valid;
  logic                            ready;
  logic [ccu_pkg::RESULT_BITS-1:0] count_value;
  logic                            overflow;
  modport source (output valid, count_value, overflow, input ready);
  modport sink (input valid, count_value, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/ccu_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Saturating shift-add multiplier, one multiplier bit per cycle.
module ccu_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire ccu_pkg::sat_t a,
  input  wire ccu_pkg::sat_t b,
  output logic               done,
  output ccu_pkg::sat_t      p
);
  localparam int W = ccu_pkg::RESULT_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  mc_r, mc_nxt;     // multiplicand, shifted left
  logic          mchi_r, mchi_nxt; // multiplicand has shifted past W bits
  logic [W-1:0]  mp_r, mp_nxt;     // multiplier, shifted right
  logic          ov_r, ov_nxt;
  logic          zero_r, zero_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    sum;

  assign sum = {1'b0, acc_r} + {1'b0, mc_r};

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mchi_nxt = mchi_r;
    mp_nxt = mp_r;
    ov_nxt = ov_r;
    zero_nxt = zero_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = a.v;
      mchi_nxt = 1'b0;
      mp_nxt = b.v;
      zero_nxt = (a.v == '0 && !a.o) || (b.v == '0 && !b.o);
      ov_nxt = a.o || b.o;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Add the shifted multiplicand when this multiplier bit is set.
      if (mp_r[0]) begin
        if (mchi_r || sum[W]) begin
          ov_nxt = 1'b1;
        end
        acc_nxt = sum[W-1:0];
      end
      mp_nxt = mp_r >> 1;
      // Bits shifted beyond W matter only if a later multiplier bit is set.
      mchi_nxt = mchi_r || mc_r[W-1];
      mc_nxt = mc_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (mp_nxt == '0 || cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mchi_r <= mchi_nxt;
    mp_r <= mp_nxt;
    ov_r <= ov_nxt;
    zero_r <= zero_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  always_comb begin
    p.o = !zero_r && ov_r;
    p.v = (zero_r || ov_r) ? '0 : acc_r;
  end
endmodule
`default_nettype wire

// ===== hdl/ccu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pascal row memory, Catalan memory, saturating adder, multiplier and result.
module ccu_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ccu_pkg::cmd_t cmd,
  output ccu_pkg::sts_t      sts,
  output logic [ccu_pkg::RESULT_BITS-1:0] res_value,
  output logic               res_ovf
);
  localparam int W = ccu_pkg::RESULT_BITS;

  ccu_pkg::sat_t row_mem [ccu_pkg::ROW_DEPTH];
  ccu_pkg::sat_t cat_mem [ccu_pkg::CAT_DEPTH];
  ccu_pkg::sat_t rda_r, rdb_r, acc_r, res_r, prod;
  ccu_pkg::sat_t one_s, add_a, add_b, add_s;
  logic [W:0]    add_w;
  logic          mul_start, mul_done;
  logic [4:0]    op_d_r;

  assign one_s = '{o: 1'b0, v: W'(1)};

  // Saturating add, operands picked by the pending operation.
  always_comb begin
    add_a = rda_r;
    add_b = rdb_r;
    case (cmd.op)
      ccu_pkg::OP_CAT_ACC: begin
        add_a = acc_r;
        add_b = prod;
      end
      ccu_pkg::OP_MZ_ACC: begin
        add_a = res_r;
        add_b = prod;
      end
      default: begin
        add_a = rda_r;
        add_b = rdb_r;
      end
    endcase
    add_w = {1'b0, add_a.v} + {1'b0, add_b.v};
    add_s.o = add_a.o || add_b.o || add_w[W];
    add_s.v = add_s.o ? '0 : add_w[W-1:0];
  end

  assign mul_start = (cmd.op == ccu_pkg::OP_CAT_MUL) || (cmd.op == ccu_pkg::OP_MZ_MUL);

  ccu_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (rda_r),
    .b    (rdb_r),
    .done (mul_done),
    .p    (prod)
  );

  // Memories: one write port, two registered read ports each.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ccu_pkg::OP_ROW_INIT: row_mem[0] <= one_s;
      ccu_pkg::OP_ROW_ZERO: row_mem[cmd.ra] <= '0;
      ccu_pkg::OP_ROW_WR:   row_mem[cmd.ra] <= add_s;
      ccu_pkg::OP_CAT_INIT: cat_mem[0] <= one_s;
      ccu_pkg::OP_CAT_WR:   cat_mem[cmd.ca] <= acc_r;
      default: ;
    endcase
    rda_r <= (cmd.op == ccu_pkg::OP_CAT_RD) ? cat_mem[cmd.ca] : row_mem[cmd.ra];
    rdb_r <= (cmd.op == ccu_pkg::OP_CAT_RD || cmd.op == ccu_pkg::OP_MZ_RD ||
              cmd.op == ccu_pkg::OP_RES_CAT)
             ? cat_mem[cmd.cb] : row_mem[cmd.rb];
    op_d_r <= cmd.op;
  end

  // Accumulator and result register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ccu_pkg::OP_CAT_INIT: acc_r <= '0;
      ccu_pkg::OP_CAT_ACC:  acc_r <= add_s;
      ccu_pkg::OP_CAT_WR:   acc_r <= '0;
      ccu_pkg::OP_RES_ZERO: res_r <= '0;
      ccu_pkg::OP_RES_ONE:  res_r <= one_s;
      ccu_pkg::OP_MZ_ACC:   res_r <= add_s;
      default: ;
    endcase
    // Row and Catalan result reads land via the registered read ports and op_d_r.
    if (op_d_r == ccu_pkg::OP_RES_ROW) begin
      res_r <= rda_r;
    end else if (op_d_r == ccu_pkg::OP_RES_CAT) begin
      res_r <= rdb_r;
    end
  end

  assign sts.mul_done = mul_done;
  assign res_value = res_r.o ? ccu_pkg::MAX_VALUE : res_r.v;
  assign res_ovf = res_r.o;
endmodule
`default_nettype wire

// ===== hdl/ccu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: walks Pascal rows, the Catalan convolution and the Motzkin sum.
module ccu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ccu_in_if.sink             in_if,
  input  wire logic          out_busy,
  output logic               out_load,
  output ccu_pkg::cmd_t      cmd,
  input  wire ccu_pkg::sts_t sts
);
  localparam int AW = ccu_pkg::ROW_AW;
  localparam int CA = ccu_pkg::CAT_AW;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_ROWI = 5'd2;
  localparam logic [4:0] S_ROWZ = 5'd3;
  localparam logic [4:0] S_ROWR = 5'd4;
  localparam logic [4:0] S_ROWW = 5'd5;
  localparam logic [4:0] S_ROWP = 5'd6;
  localparam logic [4:0] S_CATI = 5'd7;
  localparam logic [4:0] S_CATR = 5'd8;
  localparam logic [4:0] S_CATM = 5'd9;
  localparam logic [4:0] S_CATW = 5'd10;
  localparam logic [4:0] S_CATA = 5'd11;
  localparam logic [4:0] S_CATS = 5'd12;
  localparam logic [4:0] S_RRES = 5'd13;
  localparam logic [4:0] S_CRES = 5'd14;
  localparam logic [4:0] S_MZR = 5'd15;
  localparam logic [4:0] S_MZM = 5'd16;
  localparam logic [4:0] S_MZW = 5'd17;
  localparam logic [4:0] S_MZA = 5'd18;
  localparam logic [4:0] S_FIN = 5'd19;
  localparam logic [4:0] S_OUT = 5'd20;
  localparam logic [4:0] S_RWAIT = 5'd21;

  logic [4:0]    state_r, state_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [AW-1:0] rn_r, rn_nxt;    // row to build up to
  logic [AW-1:0] rk_r, rk_nxt;    // entry to read
  logic [CA-1:0] cn_r, cn_nxt;    // Catalan index limit
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          zero_r, zero_nxt;
  logic          one_r, one_nxt;
  logic [AW-1:0] n7, k7;

  assign n7 = AW'(in_if.operand_n);
  assign k7 = AW'(in_if.operand_k);
  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    rn_nxt = rn_r;
    rk_nxt = rk_r;
    cn_nxt = cn_r;
    i_nxt = i_r;
    j_nxt = j_r;
    zero_nxt = zero_r;
    one_nxt = one_r;
    out_load = 1'b0;
    cmd = '0;
    cmd.op = ccu_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          // Decode the request into row size, entry and special cases.
          func_nxt = in_if.func;
          zero_nxt = 1'b0;
          one_nxt = 1'b0;
          cn_nxt = in_if.operand_n;
          rn_nxt = n7;
          rk_nxt = k7;
          case (in_if.func)
            ccu_pkg::FN_BINOM: zero_nxt = (in_if.operand_k > in_if.operand_n);
            ccu_pkg::FN_LATTICE: begin
              rn_nxt = n7 + k7;
              rk_nxt = n7;
            end
            ccu_pkg::FN_CATALAN: ;
            ccu_pkg::FN_MOTZKIN: cn_nxt = in_if.operand_n >> 1;
            ccu_pkg::FN_MULTISET: begin
              if (in_if.operand_n == '0) begin
                zero_nxt = (in_if.operand_k != '0);
                one_nxt = (in_if.operand_k == '0);
              end else begin
                rn_nxt = n7 + k7 - AW'(1);
              end
            end
            default: zero_nxt = 1'b1;
          endcase
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (zero_r) begin
          cmd.op = ccu_pkg::OP_RES_ZERO;
          state_nxt = S_FIN;
        end else if (one_r) begin
          cmd.op = ccu_pkg::OP_RES_ONE;
          state_nxt = S_FIN;
        end else if (func_r == ccu_pkg::FN_CATALAN) begin
          state_nxt = S_CATI;
        end else begin
          state_nxt = S_ROWI;
        end
      end
      // Pascal rows: for i in 1..n, row[i]=0 then j=i..1 row[j]+=row[j-1].
      S_ROWI: begin
        cmd.op = ccu_pkg::OP_ROW_INIT;
        i_nxt = AW'(1);
        state_nxt = (rn_r == '0) ? S_ROWP : S_ROWZ;
      end
      S_ROWZ: begin
        // New entry row[i] starts at zero.
        cmd.op = ccu_pkg::OP_ROW_ZERO;
        cmd.ra = i_r;
        j_nxt = i_r;
        state_nxt = S_ROWR;
      end
      S_ROWR: begin
        cmd.op = ccu_pkg::OP_ROW_RD;
        cmd.ra = j_r;
        cmd.rb = j_r - AW'(1);
        state_nxt = S_ROWW;
      end
      S_ROWW: begin
        cmd.op = ccu_pkg::OP_ROW_WR;
        cmd.ra = j_r;
        if (j_r == AW'(1)) begin
          if (i_r == rn_r) begin
            state_nxt = S_ROWP;
          end else begin
            i_nxt = i_r + AW'(1);
            state_nxt = S_ROWZ;
          end
        end else begin
          j_nxt = j_r - AW'(1);
          state_nxt = S_ROWR;
        end
      end
      S_ROWP: begin
        // The Motzkin sum accumulates in the result register, so clear it here.
        if (func_r == ccu_pkg::FN_MOTZKIN) begin
          cmd.op = ccu_pkg::OP_RES_ZERO;
          state_nxt = S_CATI;
        end else begin
          state_nxt = S_RRES;
        end
      end
      S_RRES: begin
        cmd.op = ccu_pkg::OP_RES_ROW;
        cmd.ra = rk_r;
        state_nxt = S_RWAIT;
      end
      // Catalan: cat[i] = sum over j<i of cat[j]*cat[i-1-j].
      S_CATI: begin
        cmd.op = ccu_pkg::OP_CAT_INIT;
        i_nxt = AW'(1);
        j_nxt = '0;
        state_nxt = (cn_r == '0) ? S_CATS : S_CATR;
      end
      S_CATR: begin
        cmd.op = ccu_pkg::OP_CAT_RD;
        cmd.ca = j_r[CA-1:0];
        cmd.cb = CA'(i_r - AW'(1) - j_r);
        state_nxt = S_CATM;
      end
      S_CATM: begin
        cmd.op = ccu_pkg::OP_CAT_MUL;
        state_nxt = S_CATW;
      end
      S_CATW: begin
        if (sts.mul_done) begin
          state_nxt = S_CATA;
        end
      end
      S_CATA: begin
        cmd.op = ccu_pkg::OP_CAT_ACC;
        if (j_r + AW'(1) == i_r) begin
          state_nxt = S_CATS;
        end else begin
          j_nxt = j_r + AW'(1);
          state_nxt = S_CATR;
        end
      end
      S_CATS: begin
        if (cn_r == '0) begin
          // Nothing to store; catalan table holds cat[0] only.
          state_nxt = (func_r == ccu_pkg::FN_MOTZKIN) ? S_MZR : S_CRES;
          cmd.op = (func_r == ccu_pkg::FN_MOTZKIN) ? ccu_pkg::OP_RES_ZERO : ccu_pkg::OP_NOP;
          j_nxt = '0;
        end else begin
          cmd.op = ccu_pkg::OP_CAT_WR;
          cmd.ca = i_r[CA-1:0];
          j_nxt = '0;
          if (i_r[CA-1:0] == cn_r) begin
            state_nxt = (func_r == ccu_pkg::FN_MOTZKIN) ? S_MZR : S_CRES;
          end else begin
            i_nxt = i_r + AW'(1);
            state_nxt = S_CATR;
          end
        end
      end
      S_CRES: begin
        cmd.op = ccu_pkg::OP_RES_CAT;
        cmd.cb = cn_r;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        // The memory read reaches the result register at the end of this cycle.
        state_nxt = S_FIN;
      end
      // Motzkin: res = sum over j of row[2j]*cat[j].
      S_MZR: begin
        cmd.op = ccu_pkg::OP_MZ_RD;
        cmd.ra = AW'({j_r[CA-1:0], 1'b0});
        cmd.cb = j_r[CA-1:0];
        state_nxt = S_MZM;
      end
      S_MZM: begin
        cmd.op = ccu_pkg::OP_MZ_MUL;
        state_nxt = S_MZW;
      end
      S_MZW: begin
        if (sts.mul_done) begin
          state_nxt = S_MZA;
        end
      end
      S_MZA: begin
        cmd.op = ccu_pkg::OP_MZ_ACC;
        if (j_r[CA-1:0] == cn_r) begin
          state_nxt = S_FIN;
        end else begin
          j_nxt = j_r + AW'(1);
          state_nxt = S_MZR;
        end
      end
      S_FIN: begin
        // Hand the result over once the output register is free.
        if (!out_busy) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    func_r <= func_nxt;
    rn_r <= rn_nxt;
    rk_r <= rk_nxt;
    cn_r <= cn_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    zero_r <= zero_nxt;
    one_r <= one_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/combinatorial_count_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Contents
// in_      request    func, operand_n, operand_k
// out_     result     count_value, overflow
//
// One request at a time. Run time depends on the Pascal row builder for
// the row-based functions and, for Catalan and Motzkin, on the serial
// multiplier. Reset is synchronous, active low.
// A result waits in the output register; the next request is taken while it
// waits, and its result is held back until the output register empties.
module combinatorial_count_unit (
  input wire logic clk,
  input wire logic rst_n,
  ccu_in_if.sink   in_if,
  ccu_out_if.source out_if
);
  ccu_pkg::cmd_t cmd;
  ccu_pkg::sts_t sts;
  logic [ccu_pkg::RESULT_BITS-1:0] res_value;
  logic res_ovf, out_load;
  logic valid_r;
  logic [ccu_pkg::RESULT_BITS-1:0] value_r;
  logic ovf_r;

  ccu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_busy(valid_r && !out_if.ready),
    .out_load(out_load),
    .cmd     (cmd),
    .sts     (sts)
  );

  ccu_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .res_value(res_value),
    .res_ovf  (res_ovf)
  );

  // Output register holding one finished result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
    if (out_load) begin
      value_r <= res_value;
      ovf_r <= res_ovf;
    end
  end

  assign out_if.valid = valid_r;
  assign out_if.count_value = value_r;
  assign out_if.overflow = ovf_r;
endmodule
`default_nettype wire
